### design/button_click_classifier_assert.svh
// assertion macros shared by the checker
`ifndef BUTTON_CLICK_CLASSIFIER_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define BCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define BCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/bcc_pkg.sv
`default_nettype none

package bcc_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned IdxW  = 2;

  localparam logic [CfgW-1:0] DebounceRst  = 16'd50;
  localparam logic [CfgW-1:0] LongPressRst = 16'd800;
  localparam logic [CfgW-1:0] GapRst       = 16'd300;

  typedef enum logic [1:0] {
    MODE_IDLE           = 2'd0,
    MODE_PRESSED        = 2'd1,
    MODE_CLICK_RELEASED = 2'd2,
    MODE_LONG_PRESS     = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ACT_NONE        = 3'd0,
    ACT_STEP_UP     = 3'd1,
    ACT_OFF         = 3'd2,
    ACT_BREATHE     = 3'd3,
    ACT_BREATHE_END = 3'd4
  } action_e;

  typedef enum logic [IdxW-1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_GAP        = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] settle_ms;
    logic [CfgW-1:0] hold_ms;
    logic [CfgW-1:0] gap_ms;
  } cfg_t;

endpackage

`default_nettype wire

### design/bcc_if.sv
`default_nettype none

// input tick channel
interface bcc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        button_level;

  modport source (output valid, output now_ms, output button_level, input ready);
  modport sink   (input valid, input now_ms, input button_level, output ready);
endinterface

// result channel
interface bcc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;

  modport source (output valid, output action, input ready);
  modport sink   (input valid, input action, output ready);
endinterface

// register write channel
interface bcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/button_click_classifier.sv
// Button click classifier: one tick per input transfer (millisecond timestamp and
// raw button level) gives exactly one action code on the result channel, in order.
// A tick is captured in an input register, classified combinationally by the
// debounce latch, the three wrapping-time compares and the four-state machine, and
// lands in a result register when the held tick advances, that is once the result
// slot is free or being drained; one tick is taken every cycle while the result
// side keeps up. While a finished result waits to be taken, one
// more tick is still accepted into the input register; after that the input stalls
// until the result is taken. Registers (debounce, long-press limit, double-click
// gap, 16 bits each) are written through the config channel, which never stalls;
// write them only while no tick is in flight.
`default_nettype none

module button_click_classifier
  import bcc_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  bcc_in_if.sink   in_i,
  bcc_out_if.source out_o,
  bcc_cfg_if.sink  cfg_i
);

  // input register
  logic             in_valid_q;
  logic [TimeW-1:0] now_q;
  logic             level_q;

  // result register
  logic             out_valid_q;
  action_e          action_q;

  logic    advance;
  cfg_t    cfg;
  action_e action;

  // the held tick moves on whenever the result slot is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  // register writes are always taken
  assign cfg_i.ready = 1'b1;

  bcc_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  // state advances together with the transfer into the result register
  bcc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .now_i    (now_q),
    .level_i  (level_q),
    .cfg_i    (cfg),
    .action_o (action)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      now_q   <= in_i.now_ms;
      level_q <= in_i.button_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      action_q <= action;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.action = action_q;

endmodule

`default_nettype wire

### design/bcc_cfg_regs.sv
`default_nettype none

module bcc_cfg_regs
  import bcc_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_en_i,
  input  wire logic [IdxW-1:0] wr_idx_i,
  input  wire logic [CfgW-1:0] wr_data_i,
  output      cfg_t            cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_idx_e'(wr_idx_i))
        REG_DEBOUNCE:   cfg_d.settle_ms = wr_data_i;
        REG_LONG_PRESS: cfg_d.hold_ms   = wr_data_i;
        REG_GAP:        cfg_d.gap_ms    = wr_data_i;
        default:        cfg_d = cfg_q; // unmapped index is dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ms <= DebounceRst;
      cfg_q.hold_ms   <= LongPressRst;
      cfg_q.gap_ms    <= GapRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### design/bcc_core.sv
`default_nettype none

module bcc_core
  import bcc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [TimeW-1:0] now_i,
  input  wire logic             level_i,
  input  wire cfg_t             cfg_i,
  output      action_e          action_o
);

  logic             steady_q, steady_d;
  logic [TimeW-1:0] change_q, change_d;
  logic [TimeW-1:0] press_q, press_d;
  logic [TimeW-1:0] release_q, release_d;
  logic [1:0]       count_q, count_d;
  mode_e            mode_q, mode_d;

  logic [TimeW-1:0] since_change, since_press, since_release;
  logic             settled, hold_done, gap_done;

  // debounce latch follows the raw level at once
  assign steady_d     = level_i;
  assign change_d     = (level_i != steady_q) ? now_i : change_q;

  // wrapping differences
  assign since_change  = now_i - change_d;
  assign since_press   = now_i - press_q;
  assign since_release = now_i - release_q;

  assign settled   = since_change  >= TimeW'(cfg_i.settle_ms);
  assign hold_done = since_press   >= TimeW'(cfg_i.hold_ms);
  assign gap_done  = since_release >= TimeW'(cfg_i.gap_ms);

  // next state
  always_comb begin
    mode_d    = mode_q;
    press_d   = press_q;
    release_d = release_q;
    count_d   = count_q;
    if (settled) begin
      case (mode_q)
        MODE_IDLE: begin
          if (level_i) begin
            mode_d  = MODE_PRESSED;
            press_d = now_i;
          end
        end
        MODE_PRESSED: begin
          if (!level_i) begin
            // late release keeps the pressed state
            if (!hold_done) begin
              if (count_q != 2'd2) count_d = count_q + 2'd1;
              release_d = now_i;
              mode_d    = MODE_CLICK_RELEASED;
            end
          end else if (hold_done) begin
            count_d = 2'd0;
            mode_d  = MODE_LONG_PRESS;
          end
        end
        MODE_CLICK_RELEASED: begin
          if (level_i) begin
            mode_d  = MODE_PRESSED;
            press_d = now_i;
          end else if (gap_done) begin
            count_d = 2'd0;
            mode_d  = MODE_IDLE;
          end
        end
        MODE_LONG_PRESS: begin
          if (!level_i) mode_d = MODE_IDLE;
        end
        default: mode_d = MODE_IDLE;
      endcase
    end
  end

  // action
  always_comb begin
    action_o = ACT_NONE;
    if (settled) begin
      case (mode_q)
        MODE_CLICK_RELEASED: begin
          if (!level_i && gap_done) begin
            if (count_q == 2'd1)      action_o = ACT_STEP_UP;
            else if (count_q != 2'd0) action_o = ACT_OFF;
          end
        end
        MODE_LONG_PRESS: action_o = level_i ? ACT_BREATHE : ACT_BREATHE_END;
        default:         action_o = ACT_NONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steady_q  <= 1'b0;
      change_q  <= '0;
      press_q   <= '0;
      release_q <= '0;
      count_q   <= 2'd0;
      mode_q    <= MODE_IDLE;
    end else if (step_i) begin
      steady_q  <= steady_d;
      change_q  <= change_d;
      press_q   <= press_d;
      release_q <= release_d;
      count_q   <= count_d;
      mode_q    <= mode_d;
    end
  end

endmodule

`default_nettype wire

### design/bcc_checker.sv
`default_nettype none

`include "button_click_classifier_assert.svh"

module bcc_checker
  import bcc_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [2:0] action_i,
  input wire logic       cfg_valid_i,
  input wire logic       cfg_ready_i
);

  // a stalled result keeps its code
  `BCC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(action_i))

  // only defined action codes leave the block
  `BCC_ASSERT_NOW(a_action_code, clk_i, rst_ni, out_valid_i, action_i <= 3'(ACT_BREATHE_END))

  // with the result slot empty a tick is always taken
  `BCC_ASSERT_NOW(a_in_ready_empty, clk_i, rst_ni, !out_valid_i, in_ready_i)

  // register writes never stall
  `BCC_ASSERT_NOW(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_i)

  // a tick taken with the result slot empty shows up as a result
  `BCC_ASSERT_NEXT(a_in_flows, clk_i, rst_ni, in_valid_i && in_ready_i && !out_valid_i, ##1 out_valid_i)

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .action_i    (out_o.action),
  .cfg_valid_i (cfg_i.valid),
  .cfg_ready_i (cfg_i.ready)
);

`default_nettype wire
